>>> hdl/sliding_window_event_rate_alarm_assert.svh
// Assertion macros shared by the checker of the event rate alarm.
// No dependencies; clk and arst_n must be visible where a macro is used.
`ifndef SLIDING_WINDOW_EVENT_RATE_ALARM_ASSERT_SVH
`define SLIDING_WINDOW_EVENT_RATE_ALARM_ASSERT_SVH

// Check a property outside reset.
`define SWERA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check a property at every edge, reset included.
`define SWERA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/swera_pkg.sv
// Types and constants of the sliding window event rate alarm.
// No dependencies; imported by all modules of the block.
package swera_pkg;

	localparam int ADDR_W = 5;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_EXPIRE_AFTER        = 3'd0;
	localparam reg_idx_t REG_ACTIVITY_LOW        = 3'd1;
	localparam reg_idx_t REG_ACTIVITY_HIGH       = 3'd2;
	localparam reg_idx_t REG_HIGH_RATE_ABOVE     = 3'd3;
	localparam reg_idx_t REG_RENAME_MODIFY_ABOVE = 3'd4;
	localparam reg_idx_t REG_EXTENSION_ABOVE     = 3'd5;

	localparam logic [31:0] RST_EXPIRE_AFTER        = 32'd3000;
	localparam logic [8:0]  RST_ACTIVITY_LOW        = 9'd3;
	localparam logic [8:0]  RST_ACTIVITY_HIGH       = 9'd5;
	localparam logic [8:0]  RST_HIGH_RATE_ABOVE     = 9'd6;
	localparam logic [8:0]  RST_RENAME_MODIFY_ABOVE = 9'd5;
	localparam logic [8:0]  RST_EXTENSION_ABOVE     = 9'd3;

	// Largest value the reported modify count can show
	localparam logic [8:0] COUNT_SAT = 9'h1FF;

	typedef struct packed {
		logic [31:0] timestamp_ms;
		logic        event_kind;
		logic        suspicious_extension;
		logic        note_name;
		logic        batch_end;
	} event_item_t;

	typedef struct packed {
		logic       activity_alert;
		logic       high_rate_warning;
		logic       rename_modify_alarm;
		logic       extension_alarm;
		logic       note_alarm;
		logic [8:0] modify_count;
	} alert_item_t;

	typedef struct packed {
		logic [31:0] expire_after;
		logic [8:0]  activity_low;
		logic [8:0]  activity_high;
		logic [8:0]  high_rate_above;
		logic [8:0]  rename_modify_above;
		logic [8:0]  extension_above;
	} swera_cfg_t;

	// One stored event
	typedef struct packed {
		logic [31:0] time_ms;
		logic        kind;
		logic        ext;
		logic        note;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_EXP_RD,
		S_EXP_CHK,
		S_EVAL
	} swera_state_t;

endpackage

>>> hdl/swera_regs.sv
// Configuration registers of the event rate alarm behind an APB-style port.
// Depends on swera_pkg for register indexes, reset values and the config struct.
module swera_regs import swera_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output swera_cfg_t        cfg
);

	reg_idx_t   idx;
	logic       wr_en;
	swera_cfg_t cfg_q;

	assign idx    = paddr[ADDR_W-1:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// Write the addressed register; ignore addresses beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expire_after        <= RST_EXPIRE_AFTER;
			cfg_q.activity_low        <= RST_ACTIVITY_LOW;
			cfg_q.activity_high       <= RST_ACTIVITY_HIGH;
			cfg_q.high_rate_above     <= RST_HIGH_RATE_ABOVE;
			cfg_q.rename_modify_above <= RST_RENAME_MODIFY_ABOVE;
			cfg_q.extension_above     <= RST_EXTENSION_ABOVE;
		end else if (wr_en) begin
			case (idx)
				REG_EXPIRE_AFTER:        cfg_q.expire_after        <= pwdata;
				REG_ACTIVITY_LOW:        cfg_q.activity_low        <= pwdata[8:0];
				REG_ACTIVITY_HIGH:       cfg_q.activity_high       <= pwdata[8:0];
				REG_HIGH_RATE_ABOVE:     cfg_q.high_rate_above     <= pwdata[8:0];
				REG_RENAME_MODIFY_ABOVE: cfg_q.rename_modify_above <= pwdata[8:0];
				REG_EXTENSION_ABOVE:     cfg_q.extension_above     <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (idx)
			REG_EXPIRE_AFTER:        prdata = cfg_q.expire_after;
			REG_ACTIVITY_LOW:        prdata = {23'd0, cfg_q.activity_low};
			REG_ACTIVITY_HIGH:       prdata = {23'd0, cfg_q.activity_high};
			REG_HIGH_RATE_ABOVE:     prdata = {23'd0, cfg_q.high_rate_above};
			REG_RENAME_MODIFY_ABOVE: prdata = {23'd0, cfg_q.rename_modify_above};
			REG_EXTENSION_ABOVE:     prdata = {23'd0, cfg_q.extension_above};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

>>> hdl/swera_core.sv
// Event ring memory, running window counts, expiry walk and rule evaluation.
// Depends on swera_pkg for item, entry, config and state types.
module swera_core import swera_pkg::*; #(
	parameter int EVENT_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  swera_cfg_t  cfg,
	input  logic        event_valid,
	output logic        event_stall,
	input  event_item_t event_item,
	output logic        alert_valid,
	input  logic        alert_stall,
	output alert_item_t alert_item
);

	localparam int AW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
	localparam int CW = $clog2(EVENT_DEPTH + 1);
	localparam int KW = (CW > 9) ? CW : 9;

	swera_state_t state_q, state_nxt;

	// Ring of stored events; read data registered
	entry_t mem [EVENT_DEPTH];
	entry_t rd_q;
	entry_t wr_data;

	event_item_t item_q;
	alert_item_t alert_q;
	logic        alert_valid_q;

	logic [AW-1:0] oldest_q, newest_q, oldest_nxt, newest_nxt;
	logic [CW-1:0] stored_q, mods_q, renames_q, exts_q, notes_q;
	logic          warn_given_q, ren_given_q, ext_given_q, note_given_q;

	logic        accept, full, expire, eval_go;
	logic        mem_re, mem_we, do_insert, do_expire, do_eval;
	logic [31:0] age;

	logic [KW-1:0] mods_k, ren_k, ext_k;
	logic          act, warn, ren, exta, nota, clear;

	assign event_stall = (state_q != S_IDLE);
	assign accept      = event_valid && !event_stall;
	assign full        = (stored_q == CW'(EVENT_DEPTH));
	assign oldest_nxt  = (oldest_q == AW'(EVENT_DEPTH - 1)) ? '0 : oldest_q + AW'(1);
	assign newest_nxt  = (newest_q == AW'(EVENT_DEPTH - 1)) ? '0 : newest_q + AW'(1);
	assign age         = item_q.timestamp_ms - rd_q.time_ms;
	assign expire      = (age > cfg.expire_after);
	assign eval_go     = !alert_valid_q || !alert_stall;

	assign wr_data.time_ms = item_q.timestamp_ms;
	assign wr_data.kind    = item_q.event_kind;
	assign wr_data.ext     = item_q.suspicious_extension;
	assign wr_data.note    = item_q.note_name;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE:    if (accept) state_nxt = S_INSERT;
			S_INSERT:  state_nxt = item_q.batch_end ? S_EXP_RD : S_IDLE;
			S_EXP_RD:  state_nxt = (stored_q == '0) ? S_EVAL : S_EXP_CHK;
			S_EXP_CHK: state_nxt = expire ? S_EXP_RD : S_EVAL;
			S_EVAL:    if (eval_go) state_nxt = S_IDLE;
			default:   state_nxt = S_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		do_insert = 1'b0;
		do_expire = 1'b0;
		do_eval   = 1'b0;
		case (state_q)
			S_IDLE:    mem_re = accept;
			S_INSERT: begin
				mem_we    = 1'b1;
				do_insert = 1'b1;
			end
			S_EXP_RD:  mem_re = (stored_q != '0);
			S_EXP_CHK: do_expire = expire;
			S_EVAL:    do_eval = eval_go;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_nxt;
	end

	// Memory: one write port, one registered read port at the oldest slot
	always_ff @(posedge clk) begin
		if (mem_we) mem[newest_nxt] <= wr_data;
		if (mem_re) rd_q <= mem[oldest_q];
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (accept) item_q <= event_item;
	end

	// Rules on counts taken before any emptying
	always_comb begin
		mods_k = KW'(mods_q);
		ren_k  = KW'(renames_q);
		ext_k  = KW'(exts_q);
		act    = (mods_k >= KW'(cfg.activity_low)) && (mods_k <= KW'(cfg.activity_high))
			&& !warn_given_q;
		warn   = (mods_k > KW'(cfg.high_rate_above)) && !warn_given_q;
		ren    = (mods_k > KW'(cfg.rename_modify_above))
			&& (ren_k > KW'(cfg.rename_modify_above)) && !ren_given_q;
		exta   = (ext_k > KW'(cfg.extension_above)) && !ext_given_q;
		nota   = (notes_q != '0) && !note_given_q;
		clear  = ren || exta || nota;
	end

	// Pointers, window counts and sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q     <= '0;
			newest_q     <= AW'(EVENT_DEPTH - 1);
			stored_q     <= '0;
			mods_q       <= '0;
			renames_q    <= '0;
			exts_q       <= '0;
			notes_q      <= '0;
			warn_given_q <= 1'b0;
			ren_given_q  <= 1'b0;
			ext_given_q  <= 1'b0;
			note_given_q <= 1'b0;
		end else if (do_insert) begin
			// Drop the overwritten oldest entry when full, add the new one
			newest_q  <= newest_nxt;
			mods_q    <= mods_q - CW'(full && !rd_q.kind) + CW'(!item_q.event_kind);
			renames_q <= renames_q - CW'(full && rd_q.kind) + CW'(item_q.event_kind);
			exts_q    <= exts_q - CW'(full && rd_q.ext) + CW'(item_q.suspicious_extension);
			notes_q   <= notes_q - CW'(full && rd_q.note) + CW'(item_q.note_name);
			if (full) oldest_q <= oldest_nxt;
			else      stored_q <= stored_q + CW'(1);
		end else if (do_expire) begin
			// Advance past an entry older than the window
			oldest_q  <= oldest_nxt;
			stored_q  <= stored_q - CW'(1);
			mods_q    <= mods_q - CW'(!rd_q.kind);
			renames_q <= renames_q - CW'(rd_q.kind);
			exts_q    <= exts_q - CW'(rd_q.ext);
			notes_q   <= notes_q - CW'(rd_q.note);
		end else if (do_eval) begin
			if (warn) warn_given_q <= 1'b1;
			if (ren)  ren_given_q  <= 1'b1;
			if (exta) ext_given_q  <= 1'b1;
			if (nota) note_given_q <= 1'b1;
			if (clear) begin
				oldest_q  <= '0;
				newest_q  <= AW'(EVENT_DEPTH - 1);
				stored_q  <= '0;
				mods_q    <= '0;
				renames_q <= '0;
				exts_q    <= '0;
				notes_q   <= '0;
			end
		end
	end

	// Output register: load on evaluation, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)          alert_valid_q <= 1'b0;
		else if (do_eval)     alert_valid_q <= 1'b1;
		else if (!alert_stall) alert_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (do_eval) begin
			alert_q.activity_alert      <= act;
			alert_q.high_rate_warning   <= warn;
			alert_q.rename_modify_alarm <= ren;
			alert_q.extension_alarm     <= exta;
			alert_q.note_alarm          <= nota;
			alert_q.modify_count        <= (mods_k > KW'(COUNT_SAT)) ? COUNT_SAT : mods_k[8:0];
		end
	end

	assign alert_valid = alert_valid_q;
	assign alert_item  = alert_q;

endmodule

>>> hdl/sliding_window_event_rate_alarm.sv
// An item without batch_end is stored and gives no result; a batch_end item is stored, then
// the expiry walk reads and checks the oldest entries through the single registered read port,
// and the rules are evaluated into the output register. The input stalls until an item is done,
// so no new item is taken before the last one is through; a stalled result holds the evaluation.
// Reset (arst_n low, asynchronous): empty window, sticky flags clear, registers at
// their defaults; the event memory is not cleared and needs no clearing pass.
module sliding_window_event_rate_alarm import swera_pkg::*; #(
	parameter int EVENT_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              event_valid,
	output logic              event_stall,
	input  event_item_t       event_item,
	output logic              alert_valid,
	input  logic              alert_stall,
	output alert_item_t       alert_item
);

	swera_cfg_t cfg;

	// Configuration registers
	swera_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Event window and detection
	swera_core #(
		.EVENT_DEPTH (EVENT_DEPTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item),
		.alert_valid (alert_valid),
		.alert_stall (alert_stall),
		.alert_item  (alert_item)
	);

endmodule

>>> hdl/swera_checker.sv
// Port-level checks of the event rate alarm, bound to the top level.
// Depends on swera_pkg and the assertion macro header.
`include "sliding_window_event_rate_alarm_assert.svh"

module swera_checker import swera_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              event_valid,
	input logic              event_stall,
	input event_item_t       event_item,
	input logic              alert_valid,
	input logic              alert_stall,
	input alert_item_t       alert_item
);

	logic ev_take;
	assign ev_take = event_valid && !event_stall;

	// Reset leaves the block idle with no result pending from the next edge on
	`SWERA_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (!alert_valid && !event_stall), "not idle in reset")

	// An accepted item keeps the input stalled while it is stored
	`SWERA_ASSERT(a_busy_after_take, ev_take |=> event_stall, "input not stalled after an item")

	// An item without batch end never raises a result right away
	`SWERA_ASSERT(a_no_result_midbatch, (ev_take && !event_item.batch_end) |=> !$rose(alert_valid), "result for a non batch-end item")

	// A stalled result holds
	`SWERA_ASSERT(a_alert_hold, (alert_valid && alert_stall) |=> (alert_valid && $stable(alert_item)), "stalled result changed")

endmodule

bind sliding_window_event_rate_alarm swera_checker u_swera_checker (.*);

>>> bench/swera_alert_checker.sv
// Checker for the sliding window event rate alarm: watches the register port and both
// item channels, predicts each alert item and compares it field by field.
// Depends on swera_pkg for the item, register index and limit types.
module swera_alert_checker import swera_pkg::*; #(
	parameter int EVENT_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              event_valid,
	input  logic              event_stall,
	input  event_item_t       event_item,
	input  logic              alert_valid,
	input  logic              alert_stall,
	input  alert_item_t       alert_item,
	output int unsigned       fail_count,
	output int unsigned       pending
);

	// Shadow of the event window and the sticky flags
	entry_t      ring [EVENT_DEPTH];
	int unsigned oldest;
	int unsigned newest;
	int unsigned fill;
	logic        warned;
	logic        rename_fired;
	logic        ext_fired;
	logic        note_fired;
	swera_cfg_t  limits;

	// Alert items still owed by the block, oldest first
	alert_item_t alerts_due [$];
	alert_item_t want;
	int unsigned mismatches;

	function automatic int unsigned next_slot(int unsigned s);
		return (s + 1 >= EVENT_DEPTH) ? 0 : s + 1;
	endfunction

	function automatic string alert_text(alert_item_t a);
		return $sformatf("act=%0b warn=%0b ren=%0b ext=%0b note=%0b mods=%0d",
			a.activity_alert, a.high_rate_warning, a.rename_modify_alarm,
			a.extension_alarm, a.note_alarm, a.modify_count);
	endfunction

	task automatic clear_window();
		oldest = 0;
		newest = EVENT_DEPTH - 1;
		fill   = 0;
	endtask

	// Store one event; on a batch end expire stale entries, count and apply the rules
	task automatic window_step(input event_item_t ev);
		logic [31:0] age;
		int unsigned mods;
		int unsigned renames;
		int unsigned flagged;
		int unsigned slot;
		logic        note_seen;
		alert_item_t res;

		newest = next_slot(newest);
		ring[newest] = {ev.timestamp_ms, ev.event_kind, ev.suspicious_extension, ev.note_name};
		if (fill < EVENT_DEPTH) begin
			fill++;
		end else begin
			oldest = next_slot(oldest);
		end
		if (!ev.batch_end) return;

		// Expire from the oldest end, stop at the first entry inside the window
		while (fill > 0) begin
			age = ev.timestamp_ms - ring[oldest].time_ms;
			if (age <= limits.expire_after) break;
			oldest = next_slot(oldest);
			fill--;
		end

		// Count what is left
		mods      = 0;
		renames   = 0;
		flagged   = 0;
		note_seen = 1'b0;
		slot      = oldest;
		for (int unsigned i = 0; i < fill; i++) begin
			if (ring[slot].kind) renames++;
			else mods++;
			if (ring[slot].ext) flagged++;
			if (ring[slot].note) note_seen = 1'b1;
			slot = next_slot(slot);
		end

		// Apply the rules on counts taken before any clearing
		res = '0;
		res.activity_alert = mods >= limits.activity_low && mods <= limits.activity_high &&
			!warned;
		if (mods > limits.high_rate_above && !warned) begin
			res.high_rate_warning = 1'b1;
			warned = 1'b1;
		end
		if (mods > limits.rename_modify_above && renames > limits.rename_modify_above &&
			!rename_fired) begin
			res.rename_modify_alarm = 1'b1;
			rename_fired = 1'b1;
			clear_window();
		end
		if (flagged > limits.extension_above && !ext_fired) begin
			res.extension_alarm = 1'b1;
			ext_fired = 1'b1;
			clear_window();
		end
		if (note_seen && !note_fired) begin
			res.note_alarm = 1'b1;
			note_fired = 1'b1;
			clear_window();
		end
		res.modify_count = (mods > COUNT_SAT) ? COUNT_SAT : mods[8:0];
		alerts_due.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_window();
			warned       = 1'b0;
			rename_fired = 1'b0;
			ext_fired    = 1'b0;
			note_fired   = 1'b0;
			limits = {RST_EXPIRE_AFTER, RST_ACTIVITY_LOW, RST_ACTIVITY_HIGH, RST_HIGH_RATE_ABOVE,
				RST_RENAME_MODIFY_ABOVE, RST_EXTENSION_ABOVE};
			alerts_due.delete();
			mismatches = 0;
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_EXPIRE_AFTER:        limits.expire_after        = pwdata;
				REG_ACTIVITY_LOW:        limits.activity_low        = pwdata[8:0];
				REG_ACTIVITY_HIGH:       limits.activity_high       = pwdata[8:0];
				REG_HIGH_RATE_ABOVE:     limits.high_rate_above     = pwdata[8:0];
				REG_RENAME_MODIFY_ABOVE: limits.rename_modify_above = pwdata[8:0];
				REG_EXTENSION_ABOVE:     limits.extension_above     = pwdata[8:0];
				default: ;
				endcase
			end

			// Compare an accepted alert item with the oldest prediction
			if (alert_valid && !alert_stall) begin
				if (alerts_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("alert item with no event pending: got %s",
							alert_text(alert_item));
				end else begin
					want = alerts_due.pop_front();
					if (alert_item.activity_alert !== want.activity_alert ||
						alert_item.high_rate_warning !== want.high_rate_warning ||
						alert_item.rename_modify_alarm !== want.rename_modify_alarm ||
						alert_item.extension_alarm !== want.extension_alarm ||
						alert_item.note_alarm !== want.note_alarm ||
						alert_item.modify_count !== want.modify_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display("alert item mismatch: expected %s, got %s",
								alert_text(want), alert_text(alert_item));
					end
				end
			end

			// Predict from an accepted event item
			if (event_valid && !event_stall) window_step(event_item);
		end
		pending    <= alerts_due.size();
		fail_count <= mismatches;
	end

endmodule

>>> bench/tb_top.sv
// Testbench top for the sliding window event rate alarm: drives event items and
// register writes, stalls the alert side at random and reports the verdict.
// Depends on swera_pkg, sliding_window_event_rate_alarm and swera_alert_checker.
module tb_top;
	import swera_pkg::*;

	localparam int DEPTH       = 256;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int DRAIN_WAIT  = 600;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [ADDR_W-1:0] paddr       = '0;
	logic [31:0]       pwdata      = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              event_valid = 1'b0;
	logic              event_stall;
	event_item_t       event_item  = '0;
	logic              alert_valid;
	logic              alert_stall = 1'b0;
	alert_item_t       alert_item;
	int unsigned       fail_count;
	int unsigned       pending;

	// Idle percentages of the sender and the receiver
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sliding_window_event_rate_alarm #(
		.EVENT_DEPTH(DEPTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item),
		.alert_valid (alert_valid),
		.alert_stall (alert_stall),
		.alert_item  (alert_item)
	);

	swera_alert_checker #(
		.EVENT_DEPTH(DEPTH)
	) i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.event_valid (event_valid),
		.event_stall (event_stall),
		.event_item  (event_item),
		.alert_valid (alert_valid),
		.alert_stall (alert_stall),
		.alert_item  (alert_item),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Stall the alert side at random
	always @(posedge clk) begin
		alert_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic event_item_t mk_event(logic [31:0] t, logic kind, logic ext,
		logic note, logic last);
		event_item_t ev;
		ev.timestamp_ms         = t;
		ev.event_kind           = kind;
		ev.suspicious_extension = ext;
		ev.note_name            = note;
		ev.batch_end            = last;
		return ev;
	endfunction

	function automatic logic [8:0] pick_level();
		case ($urandom_range(7))
		0:       return 9'd0;
		1:       return 9'd256;
		default: return 9'($urandom_range(12));
		endcase
	endfunction

	// Present one item after a random gap, hold it until accepted
	task automatic send_event(event_item_t ev);
		while ($urandom_range(99) < gap_pct) begin
			event_valid <= 1'b0;
			@(posedge clk);
		end
		event_valid <= 1'b1;
		event_item  <= ev;
		do @(posedge clk); while (event_stall);
	endtask

	// Drop valid, wait for every owed alert item, then let a pending store finish
	task automatic settle();
		event_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Setup and access cycle; psel stays high so writes can follow back to back
	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic load_limits(swera_cfg_t lim);
		apb_write(REG_EXPIRE_AFTER, lim.expire_after);
		apb_write(REG_ACTIVITY_LOW, 32'(lim.activity_low));
		apb_write(REG_ACTIVITY_HIGH, 32'(lim.activity_high));
		apb_write(REG_HIGH_RATE_ABOVE, 32'(lim.high_rate_above));
		apb_write(REG_RENAME_MODIFY_ABOVE, 32'(lim.rename_modify_above));
		apb_write(REG_EXTENSION_ABOVE, 32'(lim.extension_above));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		swera_cfg_t  lim;
		logic [31:0] t0;
		logic [31:0] now;
		logic [31:0] stride;
		int unsigned sent;
		int unsigned run_len;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset limits, activity range edges, expiry boundary and wrap
		t0 = 32'hFFFF_F000;
		send_event(mk_event(t0, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(t0 + 10, 1'b0, 1'b0, 1'b0, 1'b1));
		send_event(mk_event(t0 + 20, 1'b0, 1'b0, 1'b0, 1'b1));
		send_event(mk_event(t0 + 30, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(t0 + 40, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(t0 + 60, 1'b0, 1'b0, 1'b0, 1'b1));
		// Only the first entry is older than the window; the next sits exactly at it
		send_event(mk_event(t0 + 3010, 1'b0, 1'b0, 1'b0, 1'b1));
		// Jump across the 32-bit wrap so that every earlier entry expires
		send_event(mk_event(t0 + 10000, 1'b0, 1'b0, 1'b0, 1'b1));
		// Renamed files with suspicious extensions raise the extension alarm
		for (int k = 1; k <= 4; k++)
			send_event(mk_event(t0 + 10000 + k, 1'b1, 1'b1, 1'b0, k == 4));

		settle();
		lim = {32'hFFFF_FFFF, 9'd0, 9'd256, 9'd256, 9'd0, 9'd256};
		load_limits(lim);
		// Rename and note alarm on the same item, both from counts before clearing
		send_event(mk_event(t0 + 10100, 1'b0, 1'b0, 1'b0, 1'b0));
		send_event(mk_event(t0 + 10100, 1'b1, 1'b0, 1'b1, 1'b1));
		send_event(mk_event(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1));
		send_event(mk_event(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b1));

		// Random phases, each with its own limits and idle pattern
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 4)
			0: begin gap_pct = 0;  stall_pct = 0;  end
			1: begin gap_pct = 66; stall_pct = 0;  end
			2: begin gap_pct = 0;  stall_pct = 66; end
			default: begin gap_pct = 38; stall_pct = 38; end
			endcase
			case (p)
			0:       lim.expire_after = 32'd0;
			1:       lim.expire_after = RST_EXPIRE_AFTER;
			default: lim.expire_after = $urandom_range(1) ? 32'($urandom_range(20, 2000)) : $urandom;
			endcase
			lim.activity_low = pick_level();
			if ($urandom_range(3) == 0 || lim.activity_low > 9'd248)
				lim.activity_high = 9'd256;
			else
				lim.activity_high = lim.activity_low + 9'($urandom_range(8));
			// Hold the warning off until the last phase; it can fire only once
			lim.high_rate_above     = (p == PHASES - 1) ? pick_level() : 9'd256;
			lim.rename_modify_above = pick_level();
			lim.extension_above     = pick_level();
			load_limits(lim);

			stride = $urandom_range(1) ? 32'd20 : 32'd400;
			now    = (p % 2) ? 32'hFFFF_FFFF - $urandom_range(20000) : $urandom;
			sent   = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(9) == 0) begin
					// Noise: any timestamp, backward jumps included
					send_event(mk_event($urandom, 1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1)), 1'($urandom_range(1))));
					sent++;
				end else begin
					// Well-formed batch, now and then long enough to wrap the ring
					run_len = ($urandom_range(24) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 8);
					for (int k = 0; k < run_len; k++) begin
						now += $urandom_range(stride);
						send_event(mk_event(now, 1'($urandom_range(1)), 1'($urandom_range(1)),
							$urandom_range(31) == 0, k == run_len - 1));
						sent++;
					end
				end
			end
		end

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// Bound the run
	initial begin
		#10_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
